@@ rtl/ordered_list_insert_remove_find_assert.svh @@
// Assertion macros for the ordered list block checkers.
`ifndef ORDERED_LIST_INSERT_REMOVE_FIND_ASSERT_SVH
`define ORDERED_LIST_INSERT_REMOVE_FIND_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define OLIRF_AST_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("olirf assertion failed");

// Next-cycle implication, masked during reset.
`define OLIRF_AST_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("olirf assertion failed");

// Next-cycle implication that also holds across reset.
`define OLIRF_AST_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("olirf assertion failed");

`endif

@@ rtl/olirf_pkg.sv @@
// Package: sizes, operation codes and cell control struct for the ordered list.
`timescale 1ns / 1ps

package olirf_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_BITS = 16;

  localparam int FUNC_W = 2;
  localparam int POS_W  = 7;
  localparam int IDX_W  = 6;
  localparam int CNT_W  = 7;

  // Find search: groups of GROUP cells, NGROUPS groups.
  localparam int GROUP   = 8;
  localparam int GRP_W   = 3;
  localparam int NGROUPS = CAPACITY / GROUP;
  localparam int NG_W    = 3;

  typedef logic [FUNC_W-1:0] func_t;

  localparam func_t FUNC_INSERT = 2'd0;
  localparam func_t FUNC_REMOVE = 2'd1;
  localparam func_t FUNC_FIND   = 2'd2;

  typedef struct packed {
    logic                ins;
    logic                rem;
    logic [CNT_W-1:0]    pos;
    logic [CNT_W-1:0]    cnt;
    logic [KEY_BITS-1:0] key;
  } cell_ctrl_t;

endpackage

@@ rtl/olirf_chan_if.sv @@
// Channel interfaces: command beats in, result beats out.
`timescale 1ns / 1ps

interface olirf_cmd_if;
  logic                              valid;
  logic                              ready;
  logic [olirf_pkg::FUNC_W-1:0]      func;
  logic [olirf_pkg::POS_W-1:0]       position;
  logic [olirf_pkg::KEY_BITS-1:0]    point_key;

  modport source (output valid, func, position, point_key, input ready);
  modport sink   (input valid, func, position, point_key, output ready);
endinterface

interface olirf_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              ok;
  logic [olirf_pkg::IDX_W-1:0]       found_index;
  logic [olirf_pkg::CNT_W-1:0]       entry_count;

  modport source (output valid, ok, found_index, entry_count, input ready);
  modport sink   (input valid, ok, found_index, entry_count, output ready);
endinterface

@@ rtl/olirf_cell.sv @@
// One list cell: holds a key, shifts with its neighbors, compares for find.
`timescale 1ns / 1ps

module olirf_cell (
  input  logic                           clk,
  input  logic [olirf_pkg::CNT_W-1:0]    idx,
  input  olirf_pkg::cell_ctrl_t          ctrl,
  input  logic [olirf_pkg::KEY_BITS-1:0] lower_key,
  input  logic [olirf_pkg::KEY_BITS-1:0] upper_key,
  output logic [olirf_pkg::KEY_BITS-1:0] key,
  output logic                           match
);

  logic [olirf_pkg::KEY_BITS-1:0] key_next;

  always_comb begin
    key_next = key;
    if (ctrl.ins) begin
      if (idx > ctrl.pos) begin
        key_next = lower_key;
      end else if (idx == ctrl.pos) begin
        key_next = ctrl.key;
      end
    end else if (ctrl.rem) begin
      if (idx >= ctrl.pos) begin
        key_next = upper_key;
      end
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
  end

  assign match = (idx < ctrl.cnt) && (key == ctrl.key);

endmodule

@@ rtl/olirf_group_enc.sv @@
// Lowest-set-bit encoder over one group of hit flags.
`timescale 1ns / 1ps

module olirf_group_enc (
  input  logic [olirf_pkg::GROUP-1:0] bits,
  output logic                        any,
  output logic [olirf_pkg::GRP_W-1:0] idx
);

  always_comb begin
    idx = '0;
    for (int i = olirf_pkg::GROUP - 1; i >= 0; i--) begin
      if (bits[i]) begin
        idx = olirf_pkg::GRP_W'(i);
      end
    end
  end

  assign any = |bits;

endmodule

@@ rtl/ordered_list_insert_remove_find.sv @@
// Top level: ordered key list held in a row of shifting cells.
`timescale 1ns / 1ps
//
// Usage:
// - cmd channel: one beat per operation (func, position, point_key).
//   func insert places point_key at min(position, count) and shifts later
//   keys up; remove takes out the entry at min(position, count - 1) and
//   shifts later keys down; find reports the lowest index holding the key.
// - rsp channel: exactly one beat per command (ok, found_index,
//   entry_count), in command order. entry_count is the count after the op.
// - Throughput: one command per cycle unless stalled. All 64 cells update
//   or compare in the cycle the command is taken, so the next command sees
//   the new list.
// - Pipeline: stage 1 holds the per-group first-hit encodings of the compare
//   row; stage 2 picks the first group and drives the output register.
// - Stall: when rsp.ready is low the output register holds; stage 1 fills,
//   then cmd.ready drops until the receiver takes the waiting beat.
// - Reset (rst, synchronous): count and all valid flags clear; the list is
//   empty. Cell contents are not cleared; cells at or above count are never
//   read, so no clearing pass is needed.
//
module ordered_list_insert_remove_find (
  input  logic               clk,
  input  logic               rst,
  olirf_cmd_if.sink          cmd,
  olirf_rsp_if.source        rsp
);

  localparam int CW = olirf_pkg::CNT_W;

  // List length
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  logic          acc;
  logic          is_ins;
  logic          is_rem;
  logic          is_find;
  logic          can_ins;
  logic          can_rem;
  logic          op_ok;
  logic [CW-1:0] pos_req;
  logic [CW-1:0] pos_clamp;
  logic [CW-1:0] pos_rem;

  olirf_pkg::cell_ctrl_t ctrl;

  logic [olirf_pkg::KEY_BITS-1:0] cell_key [olirf_pkg::CAPACITY];
  logic [olirf_pkg::CAPACITY-1:0] match;

  logic [olirf_pkg::NGROUPS-1:0]  grp_any;
  logic [olirf_pkg::GRP_W-1:0]    grp_idx [olirf_pkg::NGROUPS];

  // Stage 1
  logic                           s1_valid;
  logic                           s1_find;
  logic                           s1_ok;
  logic [CW-1:0]                  s1_cnt;
  logic [olirf_pkg::NGROUPS-1:0]  s1_hit;
  logic [olirf_pkg::GRP_W-1:0]    s1_sub [olirf_pkg::NGROUPS];
  logic                           s1_en;

  // Stage 2 (output register)
  logic                           fin_any;
  logic [olirf_pkg::NG_W-1:0]     fin_grp;
  logic                           s2_en;
  logic                           rsp_valid;
  logic                           rsp_ok;
  logic [olirf_pkg::IDX_W-1:0]    rsp_index;
  logic [CW-1:0]                  rsp_cnt;

  assign s2_en     = !rsp_valid || rsp.ready;
  assign s1_en     = !s1_valid || s2_en;
  assign cmd.ready = s1_en;
  assign acc       = cmd.valid && s1_en;

  // Operation decode
  always_comb begin
    is_ins  = 1'b0;
    is_rem  = 1'b0;
    is_find = 1'b0;
    unique case (cmd.func)
      olirf_pkg::FUNC_INSERT: is_ins  = 1'b1;
      olirf_pkg::FUNC_REMOVE: is_rem  = 1'b1;
      olirf_pkg::FUNC_FIND:   is_find = 1'b1;
      default: ;
    endcase
  end

  assign can_ins   = count < CW'(olirf_pkg::CAPACITY);
  assign can_rem   = count != '0;
  assign pos_req   = CW'(cmd.position);
  assign pos_clamp = (pos_req > count) ? count : pos_req;
  // Remove at count takes the last entry
  assign pos_rem   = (pos_clamp >= count) ? (count - CW'(1)) : pos_clamp;
  assign op_ok     = (is_ins && can_ins) || (is_rem && can_rem);

  always_comb begin
    ctrl.ins = acc && is_ins && can_ins;
    ctrl.rem = acc && is_rem && can_rem;
    ctrl.pos = is_rem ? pos_rem : pos_clamp;
    ctrl.cnt = count;
    ctrl.key = cmd.point_key;
  end

  always_comb begin
    count_next = count;
    if (ctrl.ins) begin
      count_next = count + CW'(1);
    end else if (ctrl.rem) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Row of cells; end cells feed themselves back where no neighbor exists
  for (genvar i = 0; i < olirf_pkg::CAPACITY; i++) begin : g_cell
    localparam int LO = (i == 0) ? 0 : i - 1;
    localparam int HI = (i == olirf_pkg::CAPACITY - 1) ? i : i + 1;
    olirf_cell u_cell (
      .clk       (clk),
      .idx       (CW'(i)),
      .ctrl      (ctrl),
      .lower_key (cell_key[LO]),
      .upper_key (cell_key[HI]),
      .key       (cell_key[i]),
      .match     (match[i])
    );
  end

  // First hit inside each group of cells
  for (genvar g = 0; g < olirf_pkg::NGROUPS; g++) begin : g_grp
    olirf_group_enc u_genc (
      .bits (match[g*olirf_pkg::GROUP +: olirf_pkg::GROUP]),
      .any  (grp_any[g]),
      .idx  (grp_idx[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_find <= is_find;
      s1_ok   <= op_ok;
      s1_cnt  <= count_next;
      s1_hit  <= grp_any;
      s1_sub  <= grp_idx;
    end
  end

  // First group with a hit
  olirf_group_enc u_fenc (
    .bits (s1_hit),
    .any  (fin_any),
    .idx  (fin_grp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s2_en) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en && s1_valid) begin
      rsp_cnt <= s1_cnt;
      if (s1_find) begin
        rsp_ok    <= fin_any;
        rsp_index <= fin_any ? {fin_grp, s1_sub[fin_grp]} : '0;
      end else begin
        rsp_ok    <= s1_ok;
        rsp_index <= '0;
      end
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.ok          = rsp_ok;
  assign rsp.found_index = rsp_index;
  assign rsp.entry_count = rsp_cnt;

endmodule

@@ rtl/olirf_checker.sv @@
// Port-level checks for the ordered list, bound to the top level.
`timescale 1ns / 1ps
`include "ordered_list_insert_remove_find_assert.svh"

module olirf_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic                        rsp_ok,
  input logic [olirf_pkg::IDX_W-1:0] rsp_index,
  input logic [olirf_pkg::CNT_W-1:0] rsp_cnt
);

  `OLIRF_AST_RST(a_no_beat_after_reset, rst, !rsp_valid)
  `OLIRF_AST_NXT(a_stall_holds, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_cnt))
  `OLIRF_AST_IMP(a_miss_index_zero, rsp_valid && !rsp_ok, rsp_index == '0)
  `OLIRF_AST_IMP(a_count_in_range, rsp_valid, rsp_cnt <= olirf_pkg::CNT_W'(olirf_pkg::CAPACITY))

endmodule

bind ordered_list_insert_remove_find olirf_checker u_olirf_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_ok    (rsp.ok),
  .rsp_index (rsp.found_index),
  .rsp_cnt   (rsp.entry_count)
);
